/* hw/rtl/rle8_pkg.sv */
// rle8_pkg: shared types and codes for the RLE8 bitmap decoder.
// No dependencies; imported by every rle8 module.
`timescale 1ns / 1ps

package rle8_pkg;

    localparam int BYTE_W = 8;

    // second byte of an escape pair
    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_END   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    localparam logic [1:0]        DELTA_BYTES = 2'd2;
    localparam logic [BYTE_W-1:0] LIT_COUNT   = 8'd1;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_LITERAL = 5'b00100,
        PH_PAD     = 5'b01000,
        PH_SKIP    = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] pixel_value;
        logic [BYTE_W-1:0] repeat_count;
        logic              end_of_bitmap;
    } result_t;

endpackage

/* hw/rtl/rle8_in_reg.sv */
// rle8_in_reg: input register stage of the RLE8 decoder.
// Depends on rle8_pkg (in_item_t).
`timescale 1ns / 1ps

module rle8_in_reg
    import rle8_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                s_tuser,   // [0] frame_start
    input  logic                advance,
    output logic                item_valid,
    output in_item_t            item
);

    logic     valid_reg;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.data_byte   <= s_tdata;
            item_reg.frame_start <= s_tuser;
        end
    end

endmodule

/* hw/rtl/rle8_parser.sv */
// rle8_parser: RLE8 pair/escape state machine, one byte per advance.
// Depends on rle8_pkg (phase_t, in_item_t, result_t, escape codes).
`timescale 1ns / 1ps

module rle8_parser
    import rle8_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  in_item_t item,
    output result_t  res
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] held_count_reg, held_count_next;
    logic [BYTE_W-1:0] literals_left_reg, literals_left_next;
    logic              pad_pending_reg, pad_pending_next;
    logic [1:0]        skip_left_reg, skip_left_next;
    logic              stopped_reg, stopped_next;

    phase_t            phase_cur;
    logic [BYTE_W-1:0] held_cur;
    logic [BYTE_W-1:0] lit_cur;
    logic              pad_cur;
    logic [1:0]        skip_cur;
    logic              stopped_cur;
    logic [BYTE_W-1:0] b;

    assign b = item.data_byte;

    // frame start clears everything before the byte is parsed
    always_comb begin
        if (item.frame_start) begin
            phase_cur   = PH_FIRST;
            held_cur    = '0;
            lit_cur     = '0;
            pad_cur     = 1'b0;
            skip_cur    = '0;
            stopped_cur = 1'b0;
        end else begin
            phase_cur   = phase_reg;
            held_cur    = held_count_reg;
            lit_cur     = literals_left_reg;
            pad_cur     = pad_pending_reg;
            skip_cur    = skip_left_reg;
            stopped_cur = stopped_reg;
        end
    end

    always_comb begin
        phase_next         = phase_cur;
        held_count_next    = held_cur;
        literals_left_next = lit_cur;
        pad_pending_next   = pad_cur;
        skip_left_next     = skip_cur;
        stopped_next       = stopped_cur;
        res                = '0;

        if (!stopped_cur) begin
            unique case (phase_cur)
                PH_SECOND: begin
                    phase_next = PH_FIRST;
                    if (held_cur != '0) begin
                        res.valid        = 1'b1;
                        res.pixel_value  = b;
                        res.repeat_count = held_cur;
                    end else if (b == ESC_EOL) begin
                        phase_next = PH_FIRST;
                    end else if (b == ESC_END) begin
                        stopped_next      = 1'b1;
                        res.valid         = 1'b1;
                        res.end_of_bitmap = 1'b1;
                    end else if (b == ESC_DELTA) begin
                        skip_left_next = DELTA_BYTES;
                        phase_next     = PH_SKIP;
                    end else begin
                        literals_left_next = b;
                        pad_pending_next   = b[0];
                        phase_next         = PH_LITERAL;
                    end
                end
                PH_LITERAL: begin
                    literals_left_next = lit_cur - 1'b1;
                    if (lit_cur == LIT_COUNT) begin
                        phase_next = pad_cur ? PH_PAD : PH_FIRST;
                    end
                    res.valid        = 1'b1;
                    res.pixel_value  = b;
                    res.repeat_count = LIT_COUNT;
                end
                PH_PAD: begin
                    pad_pending_next = 1'b0;
                    phase_next       = PH_FIRST;
                end
                PH_SKIP: begin
                    skip_left_next = skip_cur - 1'b1;
                    if (skip_cur == 2'd1) begin
                        phase_next = PH_FIRST;
                    end
                end
                default: begin
                    held_count_next = b;
                    phase_next      = PH_SECOND;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_FIRST;
            held_count_reg    <= '0;
            literals_left_reg <= '0;
            pad_pending_reg   <= 1'b0;
            skip_left_reg     <= '0;
            stopped_reg       <= 1'b0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            held_count_reg    <= held_count_next;
            literals_left_reg <= literals_left_next;
            pad_pending_reg   <= pad_pending_next;
            skip_left_reg     <= skip_left_next;
            stopped_reg       <= stopped_next;
        end
    end

    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("parse phase not one-hot");

    a_hold_no_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(phase_reg) && $stable(literals_left_reg) && $stable(stopped_reg))
        else $error("parser state moved without an item");

    a_stopped_first: assert property (@(posedge aclk) disable iff (!aresetn)
        stopped_reg |-> phase_reg == PH_FIRST)
        else $error("stopped outside first-byte phase");

    a_end_count: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> ((res.repeat_count == '0) == res.end_of_bitmap))
        else $error("zero count must mark end of bitmap");

    a_end_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.valid && res.end_of_bitmap |=> stopped_reg)
        else $error("end of bitmap did not stop the parser");

endmodule

/* hw/rtl/rle8_out_reg.sv */
// rle8_out_reg: result register driving the master stream side.
// Depends on rle8_pkg (result_t).
`timescale 1ns / 1ps

module rle8_out_reg
    import rle8_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  result_t               res,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*BYTE_W-1:0]   m_tdata,   // [7:0] pixel_value, [15:8] repeat_count
    output logic                  m_tlast    // end_of_bitmap
);

    logic              valid_reg;
    logic [BYTE_W-1:0] pixel_reg;
    logic [BYTE_W-1:0] count_reg;
    logic              last_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {count_reg, pixel_reg};
    assign m_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && res.valid) begin
            pixel_reg <= res.pixel_value;
            count_reg <= res.repeat_count;
            last_reg  <= res.end_of_bitmap;
        end
    end

endmodule

/* hw/rtl/rle8_bitmap_decoder.sv */
// rle8_bitmap_decoder: top level of the BMP RLE8 stream decoder.
// Depends on rle8_pkg, rle8_in_reg, rle8_parser, rle8_out_reg.
//
//   channel | dir | tdata                              | tuser / tlast
//   s_      | in  | [7:0] data_byte                    | tuser[0] frame_start
//   m_      | out | [7:0] pixel_value, [15:8] repeat   | tlast end_of_bitmap
//
// One byte per cycle sustained while m_tready is high; a result reaches m_ through the
// input register, the parser logic and the result register.
// aresetn is synchronous; it clears the parser to the first-byte phase.
// A stalled m_ side holds the result register and then the input register,
// so s_tready drops only when both are full.
`timescale 1ns / 1ps

module rle8_bitmap_decoder
    import rle8_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*BYTE_W-1:0]   m_tdata,   // [7:0] pixel_value, [15:8] repeat_count
    output logic                  m_tlast    // end_of_bitmap
);

    logic     item_valid;
    in_item_t item;
    result_t  res;
    logic     out_free;
    logic     advance;

    assign advance = item_valid && out_free;

    rle8_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rle8_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .res     (res)
    );

    rle8_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* verif/rle8_bitmap_decoder_checker.sv */
`timescale 1ns / 1ps
// rle8_bitmap_decoder_checker: watches both streams of the RLE8 decoder, decodes the
// accepted bytes itself and compares each result item in order. Depends on rle8_pkg.

module rle8_bitmap_decoder_checker
    import rle8_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,    // [7:0] data_byte
    input  logic                s_tuser,    // [0] frame_start
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [2*BYTE_W-1:0] m_tdata,    // [7:0] pixel_value, [15:8] repeat_count
    input  logic                m_tlast,    // end_of_bitmap
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_value;
        logic [BYTE_W-1:0] repeat_count;
        logic              end_of_bitmap;
    } pixel_run_t;

    pixel_run_t        expected_runs[$];
    phase_t            phase;
    logic [BYTE_W-1:0] held_count;
    logic [BYTE_W-1:0] literals_left;
    logic              pad_pending;
    logic [1:0]        skip_left;
    logic              stopped;

    function automatic void clear_parser();
        phase         = PH_FIRST;
        held_count    = '0;
        literals_left = '0;
        pad_pending   = 1'b0;
        skip_left     = '0;
        stopped       = 1'b0;
    endfunction

    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic fs,
                                       output pixel_run_t run);
        run = '0;
        if (fs)
            clear_parser();
        if (stopped)
            return 1'b0;
        case (phase)
            PH_SECOND: begin
                phase = PH_FIRST;
                if (held_count != '0) begin
                    run = '{pixel_value: b, repeat_count: held_count, end_of_bitmap: 1'b0};
                    return 1'b1;
                end
                if (b == ESC_EOL)
                    return 1'b0;
                if (b == ESC_END) begin
                    stopped = 1'b1;
                    run = '{pixel_value: '0, repeat_count: '0, end_of_bitmap: 1'b1};
                    return 1'b1;
                end
                if (b == ESC_DELTA) begin
                    skip_left = DELTA_BYTES;
                    phase     = PH_SKIP;
                    return 1'b0;
                end
                literals_left = b;
                pad_pending   = b[0];
                phase         = PH_LITERAL;
                return 1'b0;
            end
            PH_LITERAL: begin
                literals_left = literals_left - 8'd1;
                if (literals_left == '0)
                    phase = pad_pending ? PH_PAD : PH_FIRST;
                run = '{pixel_value: b, repeat_count: LIT_COUNT, end_of_bitmap: 1'b0};
                return 1'b1;
            end
            PH_PAD: begin
                pad_pending = 1'b0;
                phase       = PH_FIRST;
                return 1'b0;
            end
            PH_SKIP: begin
                skip_left = skip_left - 2'd1;
                if (skip_left == '0)
                    phase = PH_FIRST;
                return 1'b0;
            end
            default: begin
                held_count = b;
                phase      = PH_SECOND;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        pixel_run_t run;
        pixel_run_t want;
        int         errs;
        errs = 0;
        if (!aresetn) begin
            clear_parser();
            expected_runs.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (decode_byte(s_tdata, s_tuser, run))
                    expected_runs.push_back(run);
            end
            if (m_tvalid && m_tready) begin
                if (expected_runs.size() == 0) begin
                    $error("unexpected item: pixel_value %0d repeat_count %0d end_of_bitmap %0d",
                           m_tdata[7:0], m_tdata[15:8], m_tlast);
                    errs++;
                end else begin
                    want = expected_runs.pop_front();
                    if (m_tdata[7:0] !== want.pixel_value) begin
                        $error("pixel_value: expected %0d, got %0d",
                               want.pixel_value, m_tdata[7:0]);
                        errs++;
                    end
                    if (m_tdata[15:8] !== want.repeat_count) begin
                        $error("repeat_count: expected %0d, got %0d",
                               want.repeat_count, m_tdata[15:8]);
                        errs++;
                    end
                    if (m_tlast !== want.end_of_bitmap) begin
                        $error("end_of_bitmap: expected %0d, got %0d",
                               want.end_of_bitmap, m_tlast);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= expected_runs.size();
        end
    end

endmodule

/* verif/rle8_bitmap_decoder_tb.sv */
`timescale 1ns / 1ps
// rle8_bitmap_decoder_tb: drives RLE8 byte streams into rle8_bitmap_decoder with random
// idling on both sides and gives the verdict. Depends on rle8_pkg and the checker.

module rle8_bitmap_decoder_tb;
    import rle8_pkg::*;

    localparam logic [BYTE_W-1:0] ESC_MARK = 8'd0;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 430;
    localparam int TAIL_CYCLES     = 10;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [BYTE_W-1:0]   s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [2*BYTE_W-1:0] m_tdata;
    logic                m_tlast;

    int fail_count;
    int pending;
    int src_idle     = 0;
    int sink_idle    = 0;
    int live_bytes   = 0;
    int quiet_cycles = 0;
    bit frame_open   = 1'b1;
    int src_pct[3]   = '{22, 87, 0};
    int sink_pct[3]  = '{87, 22, 0};

    rle8_bitmap_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rle8_bitmap_decoder_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte(input int lo, input int hi);
        return BYTE_W'($urandom_range(hi, lo));
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fs, input bit live);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (live)
            live_bytes++;
    endtask

    // frame_start rides on the first byte after a restart
    task automatic put(input logic [BYTE_W-1:0] b);
        send_byte(b, frame_open, 1'b1);
        frame_open = 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    task automatic send_literals(input int n, input int upto);
        for (int i = 0; i < upto; i++)
            put(rand_byte(0, 255));
        if (upto == n && n[0])
            put(rand_byte(0, 255));
    endtask

    task automatic send_bitmap();
        int ncmd;
        int sel;
        int n;
        frame_open = 1'b1;
        ncmd = $urandom_range(2, 12);
        for (int c = 0; c < ncmd; c++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                put(rand_byte(1, 255));
                put(rand_byte(0, 255));
            end else if (sel < 68) begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
                put(ESC_MARK);
                put(n[BYTE_W-1:0]);
                send_literals(n, n);
            end else if (sel < 78) begin
                put(ESC_MARK);
                put(ESC_DELTA);
                put(rand_byte(0, 255));
                put(rand_byte(0, 255));
            end else if (sel < 86) begin
                put(ESC_MARK);
                put(ESC_EOL);
            end else if (sel < 96) begin
                // cut a sequence short and restart the frame on the next byte
                case ($urandom_range(0, 3))
                    0: put(rand_byte(0, 255));
                    1: begin
                        n = $urandom_range(3, 20);
                        put(ESC_MARK);
                        put(n[BYTE_W-1:0]);
                        send_literals(n, $urandom_range(0, n - 1));
                    end
                    2: begin
                        n = 2 * $urandom_range(1, 8) + 1;
                        put(ESC_MARK);
                        put(n[BYTE_W-1:0]);
                        send_literals(n, n - 1);
                        put(rand_byte(0, 255));
                    end
                    default: begin
                        put(ESC_MARK);
                        put(ESC_DELTA);
                        if ($urandom_range(0, 1))
                            put(rand_byte(0, 255));
                    end
                endcase
                frame_open = 1'b1;
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(rand_byte(0, 255), $urandom_range(0, 9) == 0, 1'b1);
                frame_open = 1'b1;
            end
        end
        if ($urandom_range(0, 99) < 85) begin
            put(ESC_MARK);
            put(ESC_END);
            repeat ($urandom_range(0, 3))
                send_byte(rand_byte(0, 255), 1'b0, 1'b0);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes of count and value, every escape, odd literal run with pad
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(ESC_MARK, 1'b0, 1'b1);
        send_byte(ESC_EOL, 1'b0, 1'b1);
        send_byte(ESC_MARK, 1'b0, 1'b1);
        send_byte(ESC_DELTA, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(ESC_MARK, 1'b0, 1'b1);
        send_byte(8'd3, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b1);
        send_byte(8'h5A, 1'b0, 1'b1);
        send_byte(ESC_MARK, 1'b0, 1'b1);
        send_byte(ESC_END, 1'b0, 1'b1);
        // ignored after end, then restart in the middle of a literal run
        send_byte(8'h07, 1'b0, 1'b0);
        send_byte(ESC_MARK, 1'b1, 1'b1);
        send_byte(8'd5, 1'b0, 1'b1);
        send_byte(8'h11, 1'b0, 1'b1);
        send_byte(8'd2, 1'b1, 1'b1);
        send_byte(8'h33, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < 3; p++) begin
            src_idle   = src_pct[p];
            sink_idle  = sink_pct[p];
            live_bytes = 0;
            while (live_bytes < ITEMS_PER_PHASE)
                send_bitmap();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rle8_pkg.sv
hw/rtl/rle8_in_reg.sv
hw/rtl/rle8_parser.sv
hw/rtl/rle8_out_reg.sv
hw/rtl/rle8_bitmap_decoder.sv
verif/rle8_bitmap_decoder_checker.sv
verif/rle8_bitmap_decoder_tb.sv
